// ===== rtl/dlht_pkg.sv =====
package dlht_pkg;

   typedef enum logic [1:0] {
      ST_LOCKED    = 2'd0,
      ST_UNLOCKED  = 2'd1,
      ST_LATCHED   = 2'd2,
      ST_LOW_POWER = 2'd3
   } dlht_state_type;

   // item kinds carried in req_tuser
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_BUTTON  = 2'd1;
   localparam logic [1:0] OP_BATTERY = 2'd2;

   // request bit masks
   localparam logic [3:0] RQ_KNOB   = 4'b0001;
   localparam logic [3:0] RQ_UNLOCK = 4'b0010;
   localparam logic [3:0] RQ_LOCK   = 4'b0100;
   localparam logic [3:0] RQ_LATCH  = 4'b1000;

   // button flag bit positions
   localparam int FLAG_EXTERIOR = 0;
   localparam int FLAG_INTERIOR = 1;
   localparam int FLAG_KNOB     = 2;

   // register indexes on the csr channel
   localparam logic [2:0] CSR_LOCK_HOLD   = 3'd0;
   localparam logic [2:0] CSR_UNLOCK_HOLD = 3'd1;
   localparam logic [2:0] CSR_WRAP_LIMIT  = 3'd2;
   localparam logic [2:0] CSR_BATT_THRESH = 3'd3;
   localparam logic [2:0] CSR_PULSE_OPEN  = 3'd4;
   localparam logic [2:0] CSR_PULSE_CLOSE = 3'd5;
   localparam logic [2:0] CSR_BLINK_PER   = 3'd6;

   typedef struct packed {
      logic [16:0] lock_hold_ticks;
      logic [16:0] unlock_hold_ticks;
      logic [17:0] wrap_limit;
      logic [9:0]  battery_threshold;
      logic [12:0] pulse_open;
      logic [12:0] pulse_close;
      logic [9:0]  blink_period;
   } dlht_cfg_type;

   typedef struct packed {
      dlht_state_type machine_state;
      logic [3:0]     request_bits;
      logic [17:0]    tick_count;
      logic [19:0]    lock_stamp;
      logic [19:0]    unlock_stamp;
      logic [19:0]    latch_stamp;
      logic           edge_falling;
      logic           servo_on;
      logic [12:0]    pulse_width;
      logic           lamp_level;
      logic [9:0]     blink_count;
   } dlht_ctx_type;

   localparam dlht_cfg_type CFG_RESET = '{
      lock_hold_ticks:   17'd693,
      unlock_hold_ticks: 17'd1155,
      wrap_limit:        18'd138600,
      battery_threshold: 10'h1A6,
      pulse_open:        13'd428,
      pulse_close:       13'd1300,
      blink_period:      10'd100
   };

   localparam dlht_ctx_type CTX_RESET = '{
      machine_state: ST_UNLOCKED,
      request_bits:  4'd0,
      tick_count:    18'd0,
      lock_stamp:    20'd0,
      unlock_stamp:  20'd0,
      latch_stamp:   20'd0,
      edge_falling:  1'b1,
      servo_on:      1'b1,
      pulse_width:   13'd1300,
      lamp_level:    1'b0,
      blink_count:   10'd0
   };

endpackage

// ===== rtl/dlht_step.sv =====
module dlht_step import dlht_pkg::*; (
   input  dlht_ctx_type ctx,
   input  dlht_cfg_type cfg,
   input  logic [1:0]   op,
   input  logic [2:0]   pin_flags,
   input  logic [9:0]   battery_sample,
   output dlht_ctx_type ctx_next,
   output logic         battery_check
);

   // age = tick - sign-extended stamp
   function automatic logic signed [21:0] age_of(logic [19:0] stamp, logic [17:0] tick);
      age_of = $signed({4'b0000, tick}) - $signed({{2{stamp[19]}}, stamp});
   endfunction

   // zero stamps stay zero across a wrap
   function automatic logic [19:0] rebase(logic [19:0] stamp, logic [18:0] tick);
      rebase = (stamp == 20'd0) ? 20'd0 : stamp - {1'b0, tick};
   endfunction

   always_comb begin
      dlht_ctx_type     nxt;
      logic [18:0]      tick_inc;
      logic             wrapped;
      logic [10:0]      blink_inc;
      logic [2:0]       f;
      logic signed [21:0] age_lock;
      logic signed [21:0] age_unlock;
      logic signed [21:0] age_latch;
      logic signed [21:0] lock_hold;
      logic signed [21:0] unlock_hold;

      nxt         = ctx;
      tick_inc    = {1'b0, ctx.tick_count} + 19'd1;
      wrapped     = 1'b0;
      blink_inc   = {1'b0, ctx.blink_count} + 11'd1;
      f           = ctx.edge_falling ? pin_flags : 3'b000;
      age_lock    = '0;
      age_unlock  = '0;
      age_latch   = '0;
      lock_hold   = $signed({5'b00000, cfg.lock_hold_ticks});
      unlock_hold = $signed({5'b00000, cfg.unlock_hold_ticks});

      case (op)
         OP_TICK: begin
            wrapped = tick_inc > {1'b0, cfg.wrap_limit};
            if (wrapped) begin
               nxt.lock_stamp   = rebase(ctx.lock_stamp, tick_inc);
               nxt.unlock_stamp = rebase(ctx.unlock_stamp, tick_inc);
               nxt.latch_stamp  = rebase(ctx.latch_stamp, tick_inc);
               nxt.tick_count   = 18'd0;
               nxt.blink_count  = 10'd0;
            end else begin
               nxt.tick_count  = tick_inc[17:0];
               nxt.blink_count = (blink_inc >= {1'b0, cfg.blink_period}) ? 10'd0
                                                                        : blink_inc[9:0];
            end

            age_lock   = age_of(nxt.lock_stamp, nxt.tick_count);
            age_unlock = age_of(nxt.unlock_stamp, nxt.tick_count);
            age_latch  = age_of(nxt.latch_stamp, nxt.tick_count);

            // commit an aged lock request
            if (nxt.machine_state != ST_LOCKED && (nxt.request_bits & RQ_LOCK) != 4'd0
                && age_lock > lock_hold) begin
               nxt.lamp_level    = 1'b1;
               nxt.lock_stamp    = 20'd0;
               nxt.request_bits  = nxt.request_bits & ~RQ_LOCK;
               nxt.machine_state = ST_LOCKED;
            end

            // commit an aged unlock, blink while it is pending
            if (nxt.machine_state == ST_LOCKED && (nxt.request_bits & RQ_UNLOCK) != 4'd0) begin
               if (age_unlock > unlock_hold) begin
                  nxt.lamp_level    = 1'b0;
                  nxt.unlock_stamp  = 20'd0;
                  nxt.request_bits  = nxt.request_bits & ~RQ_UNLOCK;
                  nxt.machine_state = ST_UNLOCKED;
               end else if (age_unlock < unlock_hold && nxt.blink_count == 10'd0) begin
                  nxt.lamp_level = ~nxt.lamp_level;
               end
            end

            // latch servo sequence
            if ((nxt.request_bits & RQ_LATCH) != 4'd0) begin
               if (age_latch > lock_hold) begin
                  nxt.machine_state = ST_LATCHED;
                  nxt.servo_on      = 1'b1;
                  nxt.pulse_width   = cfg.pulse_close;
               end
               if (age_latch > unlock_hold) begin
                  nxt.latch_stamp  = 20'd0;
                  nxt.servo_on     = 1'b0;
                  nxt.request_bits = nxt.request_bits & ~RQ_LATCH;
               end
            end
         end

         OP_BUTTON: begin
            if (f[FLAG_INTERIOR]) begin
               nxt.servo_on = 1'b0;
               if (ctx.machine_state != ST_LOCKED) begin
                  nxt.lock_stamp   = {2'b00, ctx.tick_count};
                  nxt.request_bits = ctx.request_bits | RQ_LOCK;
               end else begin
                  nxt.machine_state = ST_UNLOCKED;
                  nxt.lamp_level    = 1'b0;
               end
            end else if (f[FLAG_EXTERIOR]) begin
               nxt.servo_on = 1'b0;
               if (ctx.machine_state == ST_LOCKED) begin
                  nxt.request_bits = ctx.request_bits | RQ_UNLOCK;
                  nxt.unlock_stamp = {2'b00, ctx.tick_count};
               end
            end else if (f[FLAG_KNOB]) begin
               nxt.servo_on = 1'b1;
               if ((ctx.request_bits & RQ_KNOB) != 4'd0) begin
                  nxt.request_bits = ctx.request_bits & ~RQ_KNOB;
                  nxt.pulse_width  = cfg.pulse_close;
                  if (ctx.machine_state != ST_LOCKED) begin
                     nxt.lock_stamp   = {2'b00, ctx.tick_count};
                     nxt.request_bits = nxt.request_bits | RQ_LOCK;
                  end
               end else begin
                  nxt.request_bits = ctx.request_bits | RQ_KNOB;
                  nxt.pulse_width  = cfg.pulse_open;
                  if (ctx.machine_state == ST_LOCKED) begin
                     nxt.request_bits = nxt.request_bits | RQ_UNLOCK;
                     nxt.unlock_stamp = {2'b00, ctx.tick_count};
                  end
               end
            end else begin
               // release: drop pending lock/unlock, start re-latch unless locked or low power
               nxt.servo_on     = 1'b0;
               nxt.lock_stamp   = 20'd0;
               nxt.unlock_stamp = 20'd0;
               nxt.request_bits = ctx.request_bits & ~(RQ_LOCK | RQ_UNLOCK);
               if (ctx.machine_state != ST_LOW_POWER && ctx.machine_state != ST_LOCKED) begin
                  nxt.servo_on      = 1'b1;
                  nxt.pulse_width   = cfg.pulse_open;
                  nxt.machine_state = ST_UNLOCKED;
                  nxt.request_bits  = nxt.request_bits | RQ_LATCH;
                  nxt.latch_stamp   = {2'b00, ctx.tick_count};
                  nxt.lamp_level    = 1'b0;
               end
            end
            nxt.edge_falling = ~ctx.edge_falling;
         end

         OP_BATTERY: begin
            if (battery_sample < cfg.battery_threshold) begin
               nxt.servo_on      = 1'b1;
               nxt.pulse_width   = cfg.pulse_open;
               nxt.machine_state = ST_LOW_POWER;
            end
         end

         default: begin
         end
      endcase

      ctx_next      = nxt;
      battery_check = wrapped;
   end

endmodule

// ===== rtl/door_lock_hold_timer_fsm.sv =====
// Channel | Direction | Ports                              | Content
// req     | in        | req_tvalid/tready/tdata/tuser      | one item: tick, button or battery
// rsp     | out       | rsp_tvalid/tready/tdata            | one result per item
// csr     | in        | csr_valid/ready/index/data         | register writes
//
// An accepted item is held in the input register, then the update logic loads
// the result register and the state together. One item per cycle is sustained
// while rsp accepts; the update of the lock state is the single loop that sets
// that rate. Reset is synchronous and active high and restores state, config
// and valid flags to their defaults; payload registers are not reset. A stalled
// rsp side fills the input register and then drops req_tready; csr is always ready.
module door_lock_hold_timer_fsm import dlht_pkg::*; (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] pin_flags, [12:3] battery_sample, [15:13] zero
   input  logic [1:0]  req_tuser,   // [1:0] op

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] servo_enable, [13:1] servo_pulse, [14] lamp,
                                    // [16:15] lock_state, [17] battery_check, [23:18] zero

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [17:0] csr_data
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  in_op_ff, in_op_in;
   logic [2:0]  in_flags_ff, in_flags_in;
   logic [9:0]  in_sample_ff, in_sample_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_data_ff, out_data_in;

   dlht_ctx_type ctx_ff, ctx_in, ctx_step;
   dlht_cfg_type cfg_ff, cfg_in;
   logic         check_step;
   logic         advance;
   logic         req_take;

   // advance the held item when the result register is free or draining
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   dlht_step u_step (
      .ctx            (ctx_ff),
      .cfg            (cfg_ff),
      .op             (in_op_ff),
      .pin_flags      (in_flags_ff),
      .battery_sample (in_sample_ff),
      .ctx_next       (ctx_step),
      .battery_check  (check_step)
   );

   // input register: load on every accepted transaction
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_flags_in  = in_flags_ff;
      in_sample_in = in_sample_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in  = 1'b1;
         in_op_in     = req_tuser;
         in_flags_in  = req_tdata[2:0];
         in_sample_in = req_tdata[12:3];
      end
   end

   // state commits together with the result
   always_comb begin
      ctx_in = advance ? ctx_step : ctx_ff;
   end

   // result register: hold until the consumer takes it
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = {6'd0, check_step, ctx_step.machine_state, ctx_step.lamp_level,
                         ctx_step.pulse_width, ctx_step.servo_on};
      end
   end

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOCK_HOLD:   cfg_in.lock_hold_ticks   = csr_data[16:0];
            CSR_UNLOCK_HOLD: cfg_in.unlock_hold_ticks = csr_data[16:0];
            CSR_WRAP_LIMIT:  cfg_in.wrap_limit        = csr_data;
            CSR_BATT_THRESH: cfg_in.battery_threshold = csr_data[9:0];
            CSR_PULSE_OPEN:  cfg_in.pulse_open        = csr_data[12:0];
            CSR_PULSE_CLOSE: cfg_in.pulse_close       = csr_data[12:0];
            CSR_BLINK_PER:   cfg_in.blink_period      = csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctx_ff       <= CTX_RESET;
         cfg_ff       <= CFG_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctx_ff       <= ctx_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_op_ff     <= in_op_in;
      in_flags_ff  <= in_flags_in;
      in_sample_ff <= in_sample_in;
      out_data_ff  <= out_data_in;
   end

endmodule
